// File: sv/rhtc_pkg.sv
`timescale 1ns / 1ps

package rhtc_pkg;

   localparam int MAX_CHILDREN = 16;
   localparam int IDX_W        = $clog2(MAX_CHILDREN);
   localparam int CNT_W        = $clog2(MAX_CHILDREN + 1);

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] CSR_PARENT_X = 2'd0;
   localparam logic [1:0] CSR_PARENT_Y = 2'd1;
   localparam logic [1:0] CSR_PARENT_W = 2'd2;
   localparam logic [1:0] CSR_PARENT_H = 2'd3;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [14:0] w;
      logic [14:0] h;
   } rect_type;

   typedef struct packed {
      logic        op;
      logic [15:0] rect_x;
      logic [15:0] rect_y;
      logic [14:0] rect_w;
      logic [14:0] rect_h;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] overlap_x;
      logic [15:0] overlap_y;
      logic [14:0] overlap_w;
      logic [14:0] overlap_h;
      logic        child_outside;
      logic        table_full;
   } rsp_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [IDX_W-1:0] rd_addr;
   } mem_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PARENT,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

// File: sv/rhtc_child_mem.sv
`timescale 1ns / 1ps

module rhtc_child_mem (
   input  logic                  clock,
   input  rhtc_pkg::mem_ctl_type ctl,
   input  rhtc_pkg::rect_type    wr_data,
   output rhtc_pkg::rect_type    rd_data
);

   rhtc_pkg::rect_type mem [rhtc_pkg::MAX_CHILDREN];
   rhtc_pkg::rect_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[ctl.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/rect_hit_test_with_children.sv
`timescale 1ns / 1ps

// Rectangle hit test against a parent rectangle and a table of up to 16 children.
// Configuration: csr_ writes set the parent x, y, width and height (index 0..3);
// csr_ready is always high. Write only while the block is idle.
// Input channel req_: one word per item. An add word (op 0) appends a child and
// answers with child_outside / table_full; a query word (op 1) answers with the
// parent overlap (empty table), the first overlapping child in insertion order, or a miss.
// Every accepted word yields exactly one rsp_ word.
// An add goes from idle to the done state, and its result is then loaded into the
// output register. A query checks the parent first, then scans the children:
// they are read one per cycle from the table memory, whose read is registered.
// One item is in flight at a time; req_stall is high while it is in work, so a
// new item can be taken in the cycle after the result is loaded, while the
// previous result may still sit in the output register.
// When rsp_stall is high the output word holds and a finished result waits in
// the done state; a new item is taken only once that result has been loaded.
// Reset clears the child count, the parent registers and all valid flags.

module rect_hit_test_with_children (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rhtc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rhtc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);

   typedef struct packed {
      logic               found;
      rhtc_pkg::rect_type r;
   } hit_type;

   function automatic hit_type isect(rhtc_pkg::rect_type a, rhtc_pkg::rect_type b);
      logic signed [17:0] ax, ay, bx, by, ar, ab, br, bb, l, t, r, btm, dw, dh;
      hit_type            h;
      ax  = $signed({{2{a.x[15]}}, a.x});
      ay  = $signed({{2{a.y[15]}}, a.y});
      bx  = $signed({{2{b.x[15]}}, b.x});
      by  = $signed({{2{b.y[15]}}, b.y});
      ar  = ax + $signed({3'b000, a.w});
      ab  = ay + $signed({3'b000, a.h});
      br  = bx + $signed({3'b000, b.w});
      bb  = by + $signed({3'b000, b.h});
      l   = (ax > bx) ? ax : bx;
      t   = (ay > by) ? ay : by;
      r   = (ar < br) ? ar : br;
      btm = (ab < bb) ? ab : bb;
      dw  = r - l;
      dh  = btm - t;
      h   = '0;
      if ((a.w != '0) && (a.h != '0) && (b.w != '0) && (b.h != '0)
          && (r > l) && (btm > t)) begin
         h.found = 1'b1;
         h.r.x   = l[15:0];
         h.r.y   = t[15:0];
         h.r.w   = dw[14:0];
         h.r.h   = dh[14:0];
      end
      return h;
   endfunction

   rhtc_pkg::state_type                 state_ff, state_in;
   logic [rhtc_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [rhtc_pkg::IDX_W-1:0]          idx_ff, idx_in;
   rhtc_pkg::rect_type                  item_ff, item_in;
   rhtc_pkg::rsp_type                   res_ff, res_in;
   rhtc_pkg::rsp_type                   rsp_ff, rsp_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   rhtc_pkg::rect_type                  parent_ff, parent_in;

   rhtc_pkg::mem_ctl_type               mem_ctl;
   rhtc_pkg::rect_type                  req_rect;
   rhtc_pkg::rect_type                  rd_rect;
   rhtc_pkg::rect_type                  isect_a;
   hit_type                             hit;
   rhtc_pkg::rsp_type                   hit_rsp;
   logic                                req_accept;
   logic                                out_free;
   logic                                full;
   logic                                outside;
   logic                                last;
   logic signed [17:0]                  rq_x, rq_y, rq_r, rq_b, pa_x, pa_y, pa_r, pa_b;

   rhtc_child_mem u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_data (req_rect),
      .rd_data (rd_rect)
   );

   assign req_rect   = '{x: req_data.rect_x, y: req_data.rect_y,
                         w: req_data.rect_w, h: req_data.rect_h};
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign full       = (count_ff == rhtc_pkg::CNT_W'(rhtc_pkg::MAX_CHILDREN));
   assign last       = ((rhtc_pkg::CNT_W'(idx_ff) + rhtc_pkg::CNT_W'(1)) == count_ff);

   assign rq_x = $signed({{2{req_data.rect_x[15]}}, req_data.rect_x});
   assign rq_y = $signed({{2{req_data.rect_y[15]}}, req_data.rect_y});
   assign rq_r = rq_x + $signed({3'b000, req_data.rect_w});
   assign rq_b = rq_y + $signed({3'b000, req_data.rect_h});
   assign pa_x = $signed({{2{parent_ff.x[15]}}, parent_ff.x});
   assign pa_y = $signed({{2{parent_ff.y[15]}}, parent_ff.y});
   assign pa_r = pa_x + $signed({3'b000, parent_ff.w});
   assign pa_b = pa_y + $signed({3'b000, parent_ff.h});
   assign outside = (rq_x < pa_x) || (rq_y < pa_y) || (rq_r > pa_r) || (rq_b > pa_b);

   // share one intersect unit between the parent check and the child scan
   assign isect_a = (state_ff == rhtc_pkg::ST_PARENT) ? parent_ff : rd_rect;
   assign hit     = isect(isect_a, item_ff);

   always_comb begin
      hit_rsp           = '0;
      hit_rsp.found     = hit.found;
      hit_rsp.overlap_x = hit.r.x;
      hit_rsp.overlap_y = hit.r.y;
      hit_rsp.overlap_w = hit.r.w;
      hit_rsp.overlap_h = hit.r.h;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rhtc_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_data.op == rhtc_pkg::OP_ADD) ? rhtc_pkg::ST_DONE
                                                            : rhtc_pkg::ST_PARENT;
            end
         end
         rhtc_pkg::ST_PARENT: begin
            state_in = (!hit.found || (count_ff == '0)) ? rhtc_pkg::ST_DONE
                                                        : rhtc_pkg::ST_SCAN;
         end
         rhtc_pkg::ST_SCAN: begin
            if (hit.found || last) begin
               state_in = rhtc_pkg::ST_DONE;
            end
         end
         rhtc_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = rhtc_pkg::ST_IDLE;
            end
         end
         default: state_in = rhtc_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall       = 1'b1;
      mem_ctl.wr_en   = 1'b0;
      mem_ctl.wr_addr = count_ff[rhtc_pkg::IDX_W-1:0];
      mem_ctl.rd_addr = idx_ff + rhtc_pkg::IDX_W'(1);
      case (state_ff)
         rhtc_pkg::ST_IDLE: begin
            req_stall     = 1'b0;
            mem_ctl.wr_en = req_valid && (req_data.op == rhtc_pkg::OP_ADD) && !full;
         end
         rhtc_pkg::ST_PARENT: begin
            mem_ctl.rd_addr = '0;
         end
         rhtc_pkg::ST_SCAN: begin
         end
         rhtc_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      count_in  = count_ff;
      idx_in    = idx_ff;
      item_in   = item_ff;
      res_in    = res_ff;
      parent_in = parent_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rhtc_pkg::CSR_PARENT_X: parent_in.x = csr_data;
            rhtc_pkg::CSR_PARENT_Y: parent_in.y = csr_data;
            rhtc_pkg::CSR_PARENT_W: parent_in.w = csr_data[14:0];
            rhtc_pkg::CSR_PARENT_H: parent_in.h = csr_data[14:0];
            default: begin
            end
         endcase
      end
      case (state_ff)
         rhtc_pkg::ST_IDLE: begin
            if (req_accept) begin
               item_in = req_rect;
               if (req_data.op == rhtc_pkg::OP_ADD) begin
                  res_in               = '0;
                  res_in.child_outside = outside;
                  res_in.table_full    = full;
                  if (!full) begin
                     count_in = count_ff + rhtc_pkg::CNT_W'(1);
                  end
               end
            end
         end
         rhtc_pkg::ST_PARENT: begin
            idx_in = '0;
            res_in = (!hit.found || (count_ff == '0)) ? hit_rsp : '0;
         end
         rhtc_pkg::ST_SCAN: begin
            res_in = hit_rsp;
            idx_in = idx_ff + rhtc_pkg::IDX_W'(1);
         end
         rhtc_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
      rsp_valid_in = ((state_ff == rhtc_pkg::ST_DONE) && out_free) || (rsp_valid_ff && rsp_stall);
      rsp_in       = ((state_ff == rhtc_pkg::ST_DONE) && out_free) ? res_ff : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rhtc_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         parent_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         parent_ff    <= parent_in;
      end
      idx_ff  <= idx_in;
      item_ff <= item_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

// File: sv/rhtc_check.sv
`timescale 1ns / 1ps

module rhtc_check (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rhtc_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp word changed or dropped");

   a_found_area: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> (rsp_data.overlap_w != '0) && (rsp_data.overlap_h != '0))
      else $error("hit reported with empty overlap");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         (rsp_data.overlap_x == '0) && (rsp_data.overlap_y == '0) &&
         (rsp_data.overlap_w == '0) && (rsp_data.overlap_h == '0))
      else $error("miss reported with nonzero overlap");

   a_add_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.child_outside || rsp_data.table_full) |-> !rsp_data.found)
      else $error("add flags mixed with query hit");

endmodule

bind rect_hit_test_with_children rhtc_check u_rhtc_check (.*);
